### rtl/bfa_pkg.sv
// ---------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the best-fit block allocator and its cells.
// ---------------------------------------------------------------------------
package bfa_pkg;

   localparam int          ADDR_W     = 21;
   localparam logic [20:0] ADDR_MAX   = 21'h1FFFFF;
   localparam logic [20:0] POOL_RESET = 21'd65536;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_NOFIT     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] request_bytes;
      logic [ADDR_W-1:0] release_address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] payload_address;
      logic [ADDR_W-1:0] used_total;
      logic [ADDR_W-1:0] free_total;
   } rsp_type;

   // one table entry as held by a cell
   typedef struct packed {
      logic              live;
      logic              free;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] length;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_CLEAR,
      CELL_INSERT,
      CELL_COMPACT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          kill;
      logic          split;
      entry_type     tail;
      entry_type     ins_a;
      entry_type     ins_b;
   } ctl_type;

endpackage

### rtl/bfa_cell.sv
// ---------------------------------------------------------------------------
// bfa_cell
// One slot of the block table: holds, rotates, inserts, compacts or clears under
// the shared control word.
// ---------------------------------------------------------------------------
module bfa_cell import bfa_pkg::*; #(
   parameter int IDX_W = 5,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          ctl,
   input  logic [IDX_W-1:0] ins_index,
   input  entry_type        left_entry,
   input  entry_type        right_entry,
   output entry_type        entry
);

   localparam logic [IDX_W:0] MY_IDX = (IDX_W+1)'(INDEX);

   entry_type        entry_ff;
   entry_type        entry_in;
   logic [IDX_W:0]   k_ext;
   logic [IDX_W:0]   k_next;

   assign k_ext  = {1'b0, ins_index};
   assign k_next = k_ext + 1'b1;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         CELL_ROTATE: begin
            entry_in = right_entry;
            // absorbed neighbour arrives at the head as a dead slot
            if (INDEX == 0 && ctl.kill) begin
               entry_in.live = 1'b0;
            end
         end
         CELL_CLEAR: begin
            if (INDEX == 0) begin
               entry_in = ctl.ins_a;
            end else begin
               entry_in.live = 1'b0;
               entry_in.free = 1'b0;
            end
         end
         CELL_INSERT: begin
            if (MY_IDX == k_ext) begin
               entry_in = ctl.ins_a;
            end else if (ctl.split && MY_IDX == k_next) begin
               entry_in = ctl.ins_b;
            end else if (ctl.split && MY_IDX > k_next) begin
               entry_in = left_entry;
            end
         end
         CELL_COMPACT: begin
            // dead slots bubble towards the end, one place a cycle
            if (!entry_ff.live) begin
               entry_in = right_entry;
            end else if (!left_entry.live) begin
               entry_in = left_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         if (INDEX == 0) begin
            entry_ff <= '{live: 1'b1, free: 1'b1, offset: '0, length: POOL_RESET};
         end else begin
            entry_ff <= '{live: 1'b0, free: 1'b0, offset: '0, length: '0};
         end
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### rtl/best_fit_block_allocator_top.sv
// ---------------------------------------------------------------------------
// best_fit_block_allocator_top
// Best-fit allocator over an address-ordered table held in a ring of cells.
//
//   channel | direction | handshake            | beat
//   req_    | in        | req_valid/req_stall  | req_type
//   rsp_    | out       | rsp_valid/rsp_stall  | rsp_type
//   csr_    | in        | csr_wr_en            | pool size, 21 bits
//
// Allocate makes one full rotation of the cell ring for the best-fit search;
// free makes one each for address match and merging, then a compaction pass.
// Synchronous reset loads one free block of 65536 bytes.
// A new request is taken while an earlier result is still stalled at rsp_.
// ---------------------------------------------------------------------------
module best_fit_block_allocator_top import bfa_pkg::*; #(
   parameter int MAX_BLOCKS   = 32,
   parameter int HEADER_BYTES = 56
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [IDX_W-1:0]  LAST    = IDX_W'(MAX_BLOCKS - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);
   localparam logic [ADDR_W-1:0] HDR     = ADDR_W'(HEADER_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ASCAN,
      ST_AAPPLY,
      ST_FMATCH,
      ST_FMERGE,
      ST_COMPACT,
      ST_DONE
   } state_type;

   function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ADDR_W] ? ADDR_MAX : s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] sat_sub(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
      return (b > a) ? '0 : a - b;
   endfunction

   state_type         state_ff;
   logic [IDX_W-1:0]  step_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0] used_ff;
   logic [ADDR_W-1:0] free_ff;
   logic [ADDR_W-1:0] pool_ff;
   req_type           req_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  best_ff;
   logic [ADDR_W-1:0] best_len_ff;
   logic [ADDR_W-1:0] best_off_ff;
   logic [1:0]        status_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   entry_type         cells [MAX_BLOCKS];
   entry_type         left_w [MAX_BLOCKS];
   entry_type         right_w [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] live_vec;
   entry_type         bound_entry;
   entry_type         head;
   entry_type         nxt;
   ctl_type           ctl;

   logic              accept;
   logic              rsp_load;
   logic              scan_hit;
   logic              match_hit;
   logic              merge_hit;
   logic              split;
   logic [ADDR_W-1:0] merged_len;
   logic [ADDR_W-1:0] size;

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign bound_entry = '{live: 1'b1, free: 1'b0, offset: '0, length: '0};
   assign head        = cells[0];
   assign nxt         = cells[1];
   assign size        = req_ff.request_bytes;

   assign scan_hit  = head.live && head.free && (head.length >= size) &&
                      (!found_ff || head.length < best_len_ff);
   assign match_hit = head.live && !head.free && !found_ff &&
                      ((head.offset + HDR) == req_ff.release_address);
   // the wrapped-around first entry never merges with the last
   assign merge_hit = (step_ff != LAST) && head.live && head.free &&
                      nxt.live && nxt.free;
   assign merged_len = head.length + HDR + nxt.length;
   assign split = ({1'b0, best_len_ff} > ({1'b0, size} + {1'b0, HDR})) &&
                  (cnt_ff < CNT_MAX);

   always_comb begin
      ctl       = '0;
      ctl.mode  = CELL_HOLD;
      ctl.tail  = head;
      ctl.ins_a = head;
      ctl.ins_b = head;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.opcode == OP_CLEAR) begin
               ctl.mode  = CELL_CLEAR;
               ctl.ins_a = '{live: 1'b1, free: 1'b1, offset: '0, length: pool_ff};
            end
         end
         ST_ASCAN: begin
            ctl.mode = CELL_ROTATE;
         end
         ST_FMATCH: begin
            ctl.mode = CELL_ROTATE;
            if (match_hit) begin
               ctl.tail.free = 1'b1;
            end
         end
         ST_FMERGE: begin
            ctl.mode = CELL_ROTATE;
            if (merge_hit) begin
               ctl.tail.length = merged_len;
               ctl.kill        = 1'b1;
            end
         end
         ST_COMPACT: begin
            ctl.mode      = CELL_COMPACT;
            ctl.tail.live = 1'b0;
         end
         ST_AAPPLY: begin
            ctl.mode  = CELL_INSERT;
            ctl.split = split;
            ctl.ins_a = '{live: 1'b1, free: 1'b0, offset: best_off_ff,
                          length: split ? size : best_len_ff};
            ctl.ins_b = '{live: 1'b1, free: 1'b1,
                          offset: best_off_ff + HDR + size,
                          length: best_len_ff - size - HDR};
         end
         default: begin
         end
      endcase
   end

   for (genvar c = 0; c < MAX_BLOCKS; c++) begin : g_cell
      if (c == 0) begin : g_first
         assign left_w[c] = bound_entry;
      end else begin : g_mid_l
         assign left_w[c] = cells[c-1];
      end
      if (c == MAX_BLOCKS - 1) begin : g_last
         assign right_w[c] = ctl.tail;
      end else begin : g_mid_r
         assign right_w[c] = cells[c+1];
      end
      assign live_vec[c] = cells[c].live;

      bfa_cell #(
         .IDX_W (IDX_W),
         .INDEX (c)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .ins_index   (best_ff),
         .left_entry  (left_w[c]),
         .right_entry (right_w[c]),
         .entry       (cells[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= CNT_W'(1);
         used_ff      <= '0;
         free_ff      <= POOL_RESET;
         pool_ff      <= POOL_RESET;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pool_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff   <= req_data;
                  found_ff <= 1'b0;
                  step_ff  <= '0;
                  addr_ff  <= '0;
                  state_ff <= ST_DONE;
                  case (req_data.opcode)
                     OP_CLEAR: begin
                        cnt_ff    <= CNT_W'(1);
                        used_ff   <= '0;
                        free_ff   <= pool_ff;
                        status_ff <= STATUS_OK;
                     end
                     OP_ALLOC: begin
                        if (req_data.request_bytes == '0 ||
                            req_data.request_bytes > free_ff) begin
                           status_ff <= STATUS_INVALID;
                        end else begin
                           state_ff <= ST_ASCAN;
                        end
                     end
                     OP_FREE: begin
                        if (req_data.release_address == '0) begin
                           status_ff <= STATUS_INVALID;
                        end else begin
                           state_ff <= ST_FMATCH;
                        end
                     end
                     default: begin
                        status_ff <= STATUS_INVALID;
                     end
                  endcase
               end
            end
            ST_ASCAN: begin
               if (scan_hit) begin
                  found_ff    <= 1'b1;
                  best_ff     <= step_ff;
                  best_len_ff <= head.length;
                  best_off_ff <= head.offset;
               end
               if (step_ff == LAST) begin
                  step_ff <= '0;
                  if (found_ff || scan_hit) begin
                     state_ff <= ST_AAPPLY;
                  end else begin
                     status_ff <= STATUS_NOFIT;
                     state_ff  <= ST_DONE;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_AAPPLY: begin
               if (split) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               used_ff   <= sat_add(used_ff, size);
               free_ff   <= sat_sub(free_ff, size);
               addr_ff   <= best_off_ff + HDR;
               status_ff <= STATUS_OK;
               state_ff  <= ST_DONE;
            end
            ST_FMATCH: begin
               if (match_hit) begin
                  found_ff <= 1'b1;
                  used_ff  <= sat_sub(used_ff, head.length);
                  free_ff  <= sat_add(free_ff, head.length);
               end
               if (step_ff == LAST) begin
                  step_ff   <= '0;
                  status_ff <= (found_ff || match_hit) ? STATUS_OK : STATUS_NOT_FOUND;
                  state_ff  <= ST_FMERGE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_FMERGE: begin
               if (merge_hit) begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
               if (step_ff == LAST) begin
                  step_ff  <= '0;
                  state_ff <= ST_COMPACT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_COMPACT: begin
               if (step_ff == LAST) begin
                  step_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_ff   <= '{status: status_ff, payload_address: addr_ff,
                                used_total: used_ff, free_total: free_ff};
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // table never empties and its entry count matches the live cells while idle
   a_head_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> cells[0].live)
      else $error("head entry not live while idle");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(live_vec) == int'(cnt_ff)))
      else $error("entry count disagrees with live cells");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_MAX) && (cnt_ff != '0))
      else $error("entry count out of range");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start work");

endmodule
